[rtl/core/rcc_pkg.sv]
// rcc_pkg: shared types and constants for the ray / drum chord length block
// request and response payloads, register indexes, internal widths
// no dependencies
package rcc_pkg;

	localparam int COORD_FRAC_BITS = 8;

	localparam int CW     = 20;
	localparam int WTW    = 13;
	localparam int RADW   = 16;
	localparam int XW     = 18;
	localparam int LENW   = 20;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 18;

	localparam int AW  = 42;
	localparam int HW  = 41;
	localparam int DW  = 76;
	localparam int RDW = 38;
	localparam int LRW = 21;
	localparam int NW  = 42;
	localparam int PW  = 62;
	localparam int QW  = 20;

	localparam logic [RADW-1:0] DRUM_RADIUS_RST = 16'd7168;
	localparam logic [XW-1:0]   CRYSTAL_X_RST   = 18'd13568;

	// a * 1e8 < 2^(2F) rewritten as a < ceil(2^(2F) / 1e8)
	localparam logic [63:0] TINY_THR = 64'd1 << (2 * COORD_FRAC_BITS);
	localparam logic [63:0] TINY_LIM = (TINY_THR + 64'd99999999) / 64'd100000000;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_DRUM_RADIUS = 1'b0,
		REG_CRYSTAL_X   = 1'b1
	} cfg_reg_t;

	typedef struct packed {
		logic signed [CW-1:0] source_x;
		logic signed [CW-1:0] source_y;
		logic signed [CW-1:0] source_z;
		logic signed [CW-1:0] detector_offset;
		logic signed [CW-1:0] detector_height;
		logic [WTW-1:0]       wall_thickness;
	} req_t;

	typedef struct packed {
		logic [LENW-1:0] chord_length;
		logic            no_crossing;
		logic            source_inside;
	} rsp_t;

	typedef struct packed {
		logic                 valid;
		logic                 nocross;
		logic                 src_in;
		logic [AW-1:0]        a;
		logic signed [HW-1:0] h;
		logic [AW-1:0]        l2;
		logic [DW-1:0]        d;
	} front_t;

endpackage

[rtl/core/rcc_front.sv]
// rcc_front: seven-stage geometry front end
// forms a, half b, l^2, the quarter discriminant and the inside / no-crossing flags
// depends on rcc_pkg
module rcc_front import rcc_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  logic            in_valid,
	input  req_t            req,
	input  logic [RADW-1:0] drum_radius,
	input  logic [XW-1:0]   crystal_x,
	output front_t          front
);

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7;

	logic signed [19:0] ax_s1, ay_s1;
	logic signed [20:0] ux_s1, uz_s1;
	logic signed [21:0] uy_s1;
	logic [16:0]        r_s1;

	logic signed [41:0] ux2_s2, uy2_s2, uz2_s2;
	logic signed [40:0] hx_s2, hy_s2, cx_s2, cy_s2;
	logic signed [39:0] ax2_s2, ay2_s2;
	logic [32:0]        r2_s2;

	logic [AW-1:0]        a_s3, l2_s3;
	logic signed [HW-1:0] h_s3, c_s3, cr_s3;
	logic [32:0]          r2_s3;

	logic [39:0]          crabs_s4;
	logic                 inside_s4, tiny_s4;
	logic [AW-1:0]        a_s4, l2_s4;
	logic signed [HW-1:0] h_s4;
	logic [32:0]          r2_s4;

	logic [53:0]          arl_s5, arh_s5;
	logic [39:0]          cll_s5, clh_s5, chh_s5;
	logic                 inside_s5, tiny_s5;
	logic [AW-1:0]        a_s5, l2_s5;
	logic signed [HW-1:0] h_s5;

	logic [74:0]          ar2_s6;
	logic [79:0]          cr2_s6;
	logic                 inside_s6, tiny_s6;
	logic [AW-1:0]        a_s6, l2_s6;
	logic signed [HW-1:0] h_s6;

	logic                 nocross_s7, inside_s7;
	logic [DW-1:0]        d_s7;
	logic [AW-1:0]        a_s7, l2_s7;
	logic signed [HW-1:0] h_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			// direction from source to detector, radius with wall
			ax_s1 <= req.source_x;
			ay_s1 <= req.source_y;
			ux_s1 <= $signed({3'b000, crystal_x}) - 21'(req.source_x);
			uy_s1 <= -22'(req.detector_offset) - 22'(req.source_y);
			uz_s1 <= 21'(req.detector_height) - 21'(req.source_z);
			r_s1  <= 17'(drum_radius) + 17'(req.wall_thickness);

			ux2_s2 <= ux_s1 * ux_s1;
			uy2_s2 <= uy_s1 * uy_s1;
			uz2_s2 <= uz_s1 * uz_s1;
			hx_s2  <= ux_s1 * ax_s1;
			hy_s2  <= uy_s1 * ay_s1;
			cx_s2  <= ax_s1 * uy_s1;
			cy_s2  <= ay_s1 * ux_s1;
			ax2_s2 <= ax_s1 * ax_s1;
			ay2_s2 <= ay_s1 * ay_s1;
			r2_s2  <= r_s1 * r_s1;

			a_s3  <= $unsigned(ux2_s2 + uy2_s2);
			l2_s3 <= $unsigned(ux2_s2 + uy2_s2 + uz2_s2);
			h_s3  <= hx_s2 + hy_s2;
			c_s3  <= 41'(ax2_s2) + 41'(ay2_s2) - $signed({8'b0, r2_s2});
			cr_s3 <= cx_s2 - cy_s2;
			r2_s3 <= r2_s2;

			crabs_s4  <= cr_s3[HW-1] ? 40'(-cr_s3) : 40'(cr_s3);
			inside_s4 <= !h_s3[HW-1] || c_s3[HW-1];
			tiny_s4   <= a_s3 < TINY_LIM[AW-1:0];
			a_s4      <= a_s3;
			l2_s4     <= l2_s3;
			h_s4      <= h_s3;
			r2_s4     <= r2_s3;

			// split products for a*r^2 and cross^2
			arl_s5    <= a_s4[20:0] * r2_s4;
			arh_s5    <= a_s4[41:21] * r2_s4;
			cll_s5    <= crabs_s4[19:0] * crabs_s4[19:0];
			clh_s5    <= crabs_s4[19:0] * crabs_s4[39:20];
			chh_s5    <= crabs_s4[39:20] * crabs_s4[39:20];
			inside_s5 <= inside_s4;
			tiny_s5   <= tiny_s4;
			a_s5      <= a_s4;
			l2_s5     <= l2_s4;
			h_s5      <= h_s4;

			ar2_s6    <= (75'(arh_s5) << 21) + 75'(arl_s5);
			cr2_s6    <= (80'(chh_s5) << 40) + (80'(clh_s5) << 21) + 80'(cll_s5);
			inside_s6 <= inside_s5;
			tiny_s6   <= tiny_s5;
			a_s6      <= a_s5;
			l2_s6     <= l2_s5;
			h_s6      <= h_s5;

			nocross_s7 <= (80'(ar2_s6) <= cr2_s6) || tiny_s6;
			d_s7       <= 76'(ar2_s6) - cr2_s6[DW-1:0];
			inside_s7  <= inside_s6;
			a_s7       <= a_s6;
			l2_s7      <= l2_s6;
			h_s7       <= h_s6;
		end
	end

	always_comb begin
		front.valid   = v_s7;
		front.nocross = nocross_s7;
		front.src_in  = inside_s7;
		front.a       = a_s7;
		front.h       = h_s7;
		front.l2      = l2_s7;
		front.d       = d_s7;
	end

endmodule

[rtl/core/ray_cylinder_chord_length_top.sv]
// ray_cylinder_chord_length_top: chord length of a source-detector ray through a drum
// pipeline: 7 geometry stages, 38 square root stages (one root bit each),
// 4 product stages, 20 divide stages (one quotient bit each), 1 output register
// throughput one request per cycle; the whole pipeline holds while a response waits
// reset clears all valid bits and loads the default radius and crystal x
module ray_cylinder_chord_length_top import rcc_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  req_valid,
	output logic                  req_ready,
	input  req_t                  req,
	output logic                  rsp_valid,
	input  logic                  rsp_ready,
	output rsp_t                  rsp
);

	logic [RADW-1:0] drum_radius_q;
	logic [XW-1:0]   crystal_x_q;
	logic            en;
	front_t          front;

	logic rsp_valid_q;
	rsp_t rsp_q;

	assign en        = !rsp_valid_q || rsp_ready;
	assign req_ready = en;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			drum_radius_q <= DRUM_RADIUS_RST;
			crystal_x_q   <= CRYSTAL_X_RST;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_DRUM_RADIUS: drum_radius_q <= cfg_data[RADW-1:0];
				REG_CRYSTAL_X:   crystal_x_q   <= cfg_data[XW-1:0];
				default: ;
			endcase
		end
	end

	rcc_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.en          (en),
		.in_valid    (req_valid),
		.req         (req),
		.drum_radius (drum_radius_q),
		.crystal_x   (crystal_x_q),
		.front       (front)
	);

	// square root stages
	logic                 sq_v_s   [RDW];
	logic [DW-1:0]        sq_rem_s [RDW];
	logic [RDW-1:0]       sq_res_s [RDW];
	logic [AW-1:0]        lq_rem_s [RDW];
	logic [LRW-1:0]       lq_res_s [RDW];
	logic [AW-1:0]        sq_a_s   [RDW];
	logic signed [HW-1:0] sq_h_s   [RDW];
	logic                 sq_in_s  [RDW];
	logic                 sq_nc_s  [RDW];

	genvar j;
	generate
		for (j = 0; j < RDW; j++) begin : g_sqrt
			localparam int B = RDW - 1 - j;
			logic                 v_in, in_in, nc_in;
			logic [DW-1:0]        rem_in, trial;
			logic [RDW-1:0]       res_in;
			logic [AW-1:0]        lrem_in, a_in;
			logic [LRW-1:0]       lres_in;
			logic signed [HW-1:0] h_in;

			if (j == 0) begin : g_head
				assign v_in    = front.valid;
				assign rem_in  = front.d;
				assign res_in  = '0;
				assign lrem_in = front.l2;
				assign lres_in = '0;
				assign a_in    = front.a;
				assign h_in    = front.h;
				assign in_in   = front.src_in;
				assign nc_in   = front.nocross;
			end else begin : g_link
				assign v_in    = sq_v_s[j-1];
				assign rem_in  = sq_rem_s[j-1];
				assign res_in  = sq_res_s[j-1];
				assign lrem_in = lq_rem_s[j-1];
				assign lres_in = lq_res_s[j-1];
				assign a_in    = sq_a_s[j-1];
				assign h_in    = sq_h_s[j-1];
				assign in_in   = sq_in_s[j-1];
				assign nc_in   = sq_nc_s[j-1];
			end

			assign trial = (DW'(res_in) << (B + 1)) | (DW'(1) << (2 * B));

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					sq_v_s[j] <= 1'b0;
				end else if (en) begin
					sq_v_s[j] <= v_in;
				end
			end

			always_ff @(posedge clk) begin
				if (en) begin
					if (rem_in >= trial) begin
						sq_rem_s[j] <= rem_in - trial;
						sq_res_s[j] <= res_in | (RDW'(1) << B);
					end else begin
						sq_rem_s[j] <= rem_in;
						sq_res_s[j] <= res_in;
					end
					sq_a_s[j]  <= a_in;
					sq_h_s[j]  <= h_in;
					sq_in_s[j] <= in_in;
					sq_nc_s[j] <= nc_in;
				end
			end

			if (j < LRW) begin : g_len
				localparam int LB = LRW - 1 - j;
				logic [AW-1:0] ltrial;

				assign ltrial = (AW'(lres_in) << (LB + 1)) | (AW'(1) << (2 * LB));

				always_ff @(posedge clk) begin
					if (en) begin
						if (lrem_in >= ltrial) begin
							lq_rem_s[j] <= lrem_in - ltrial;
							lq_res_s[j] <= lres_in | (LRW'(1) << LB);
						end else begin
							lq_rem_s[j] <= lrem_in;
							lq_res_s[j] <= lres_in;
						end
					end
				end
			end else begin : g_lpass
				always_ff @(posedge clk) begin
					if (en) begin
						lq_rem_s[j] <= lrem_in;
						lq_res_s[j] <= lres_in;
					end
				end
			end
		end
	endgenerate

	// numerator, product, saturation check
	logic                 v_p1, v_p2, v_p3, v_p4;
	logic signed [NW-1:0] num_next, num_p1;
	logic [AW-1:0]        a_p1, a_p2, a_p3, a_p4;
	logic [LRW-1:0]       lr_p1;
	logic                 in_p1, in_p2, in_p3, in_p4;
	logic                 nc_p1, nc_p2, nc_p3, nc_p4;
	logic                 pos_p2, pos_p3, pos_p4;
	logic [41:0]          mlo_p2;
	logic [40:0]          mhi_p2;
	logic [PW-1:0]        prod_p3, rem_p4;
	logic                 sat_p4;

	always_comb begin
		if (sq_in_s[RDW-1]) begin
			num_next = $signed({4'b0, sq_res_s[RDW-1]}) - NW'(sq_h_s[RDW-1]);
		end else begin
			num_next = $signed({3'b0, sq_res_s[RDW-1], 1'b0});
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_p1 <= 1'b0;
			v_p2 <= 1'b0;
			v_p3 <= 1'b0;
			v_p4 <= 1'b0;
		end else if (en) begin
			v_p1 <= sq_v_s[RDW-1];
			v_p2 <= v_p1;
			v_p3 <= v_p2;
			v_p4 <= v_p3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			num_p1 <= num_next;
			a_p1   <= sq_a_s[RDW-1];
			lr_p1  <= lq_res_s[RDW-1];
			in_p1  <= sq_in_s[RDW-1];
			nc_p1  <= sq_nc_s[RDW-1];

			pos_p2 <= !num_p1[NW-1] && (num_p1 != '0);
			mlo_p2 <= num_p1[20:0] * lr_p1;
			mhi_p2 <= num_p1[40:21] * lr_p1;
			a_p2   <= a_p1;
			in_p2  <= in_p1;
			nc_p2  <= nc_p1;

			prod_p3 <= (PW'(mhi_p2) << 21) + PW'(mlo_p2);
			pos_p3  <= pos_p2;
			a_p3    <= a_p2;
			in_p3   <= in_p2;
			nc_p3   <= nc_p2;

			sat_p4 <= prod_p3 >= (PW'(a_p3) << QW);
			rem_p4 <= prod_p3;
			pos_p4 <= pos_p3;
			a_p4   <= a_p3;
			in_p4  <= in_p3;
			nc_p4  <= nc_p3;
		end
	end

	// restoring divide by a, one quotient bit per stage
	logic           dv_v_s   [QW];
	logic [PW-1:0]  dv_rem_s [QW];
	logic [QW-1:0]  dv_q_s   [QW];
	logic [AW-1:0]  dv_a_s   [QW];
	logic           dv_in_s  [QW];
	logic           dv_nc_s  [QW];
	logic           dv_pos_s [QW];
	logic           dv_sat_s [QW];

	genvar i;
	generate
		for (i = 0; i < QW; i++) begin : g_div
			localparam int K = QW - 1 - i;
			logic          v_in, in_in, nc_in, pos_in, sat_in;
			logic [PW-1:0] rem_in, dvs;
			logic [QW-1:0] q_in;
			logic [AW-1:0] a_in;

			if (i == 0) begin : g_head
				assign v_in   = v_p4;
				assign rem_in = rem_p4;
				assign q_in   = '0;
				assign a_in   = a_p4;
				assign in_in  = in_p4;
				assign nc_in  = nc_p4;
				assign pos_in = pos_p4;
				assign sat_in = sat_p4;
			end else begin : g_link
				assign v_in   = dv_v_s[i-1];
				assign rem_in = dv_rem_s[i-1];
				assign q_in   = dv_q_s[i-1];
				assign a_in   = dv_a_s[i-1];
				assign in_in  = dv_in_s[i-1];
				assign nc_in  = dv_nc_s[i-1];
				assign pos_in = dv_pos_s[i-1];
				assign sat_in = dv_sat_s[i-1];
			end

			assign dvs = PW'(a_in) << K;

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					dv_v_s[i] <= 1'b0;
				end else if (en) begin
					dv_v_s[i] <= v_in;
				end
			end

			always_ff @(posedge clk) begin
				if (en) begin
					if (rem_in >= dvs) begin
						dv_rem_s[i] <= rem_in - dvs;
						dv_q_s[i]   <= q_in | (QW'(1) << K);
					end else begin
						dv_rem_s[i] <= rem_in;
						dv_q_s[i]   <= q_in;
					end
					dv_a_s[i]   <= a_in;
					dv_in_s[i]  <= in_in;
					dv_nc_s[i]  <= nc_in;
					dv_pos_s[i] <= pos_in;
					dv_sat_s[i] <= sat_in;
				end
			end
		end
	endgenerate

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (en) begin
			rsp_valid_q <= dv_v_s[QW-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (dv_nc_s[QW-1]) begin
				rsp_q.chord_length  <= '0;
				rsp_q.no_crossing   <= 1'b1;
				rsp_q.source_inside <= 1'b0;
			end else begin
				if (!dv_pos_s[QW-1]) begin
					rsp_q.chord_length <= '0;
				end else if (dv_sat_s[QW-1]) begin
					rsp_q.chord_length <= '1;
				end else begin
					rsp_q.chord_length <= dv_q_s[QW-1];
				end
				rsp_q.no_crossing   <= 1'b0;
				rsp_q.source_inside <= dv_in_s[QW-1];
			end
		end
	end

endmodule
